### rtl/tsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Track stub follower package
// Shared constants, sequencer state types and item classes for the stub
// follower core and its slope divider.
// ----------------------------------------------------------------------------
package tsc_pkg;

	// Slope format: signed, 16 fraction bits, saturating.
	localparam int GRAD_W = 21;
	localparam logic signed [GRAD_W-1:0] GRAD_MAX = {1'b0, {(GRAD_W-1){1'b1}}};
	localparam logic signed [GRAD_W-1:0] GRAD_MIN = {1'b1, {(GRAD_W-1){1'b0}}};

	// Fraction bits that a position gains when it is scaled to slope units.
	localparam int FRAC_SHIFT = 16;

	// A start cluster may sit at most this many layers above its orientation.
	localparam logic [4:0] START_SLACK = 5'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_MUL,
		S_PROJ,
		S_TEST,
		S_ABS,
		S_DIST,
		S_COMMIT,
		S_DIVGO,
		S_DIVWAIT,
		S_EMIT
	} top_state_t;

	typedef enum logic [1:0] {
		K_START,
		K_ADVANCE,
		K_REPLACE,
		K_REJECT
	} item_kind_t;

	typedef enum logic [1:0] {
		D_IDLE,
		D_CHECK,
		D_ITER,
		D_DONE
	} div_state_t;

endpackage
`default_nettype wire

### rtl/track_stub_cluster_follower_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Track stub cluster follower core
// Follows one straight track stub through a stream of hit clusters: starts,
// advances by a layer step, or replaces the cluster of the current layer.
// ----------------------------------------------------------------------------
// Every input item gives exactly one result item. A start item, a cluster
// offered to an empty stub and a cluster in an unrelated layer go from DECODE
// to EMIT. A projected cluster passes MUL, PROJ and TEST and goes to EMIT if
// it misses its span; a replacement candidate passes ABS and DIST and goes to
// EMIT if not closer. An advance or closer replacement passes COMMIT, DIVGO
// and DIVWAIT, where the slope divider produces one quotient bit per cycle.
// in_stall stays high from acceptance until the result is written to the
// output register, which holds it while out_stall is high.
module track_stub_cluster_follower_core
	import tsc_pkg::*;
#(
	parameter int POS_WIDTH  = 20,
	parameter int LAYER_STEP = 2
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire                              func,
	input  wire  [3:0]                       layer,
	input  wire                              orient,
	input  wire logic signed [POS_WIDTH-1:0] x_pos,
	input  wire logic signed [POS_WIDTH-1:0] y_pos,
	input  wire logic signed [POS_WIDTH-1:0] z_pos,
	input  wire logic signed [POS_WIDTH-1:0] extent_low,
	input  wire logic signed [POS_WIDTH-1:0] extent_high,
	input  wire logic signed [POS_WIDTH-1:0] span_low,
	input  wire logic signed [POS_WIDTH-1:0] span_high,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic                             accepted,
	output logic                             replaced,
	output logic [3:0]                       stub_layer,
	output logic signed [POS_WIDTH-1:0]      stub_position,
	output logic signed [GRAD_W-1:0]         stub_slope
);

	localparam int P   = POS_WIDTH;
	localparam int SW  = P + 1;
	localparam int PRW = P + GRAD_W + 1;
	localparam int PW  = P + GRAD_W + 2;
	localparam int DFW = PW + 1;

	top_state_t state_q, state_d;
	item_kind_t kind_c, kind_q;

	// Item registers.
	logic                func_q;
	logic [3:0]          layer_q;
	logic                orient_q;
	logic signed [P-1:0] x_q, y_q, z_q, el_q, eh_q, sl_q, sh_q;

	// Stub state.
	logic                has_q;
	logic [3:0]          cur_layer_q;
	logic                orient_bit_q;
	logic signed [P-1:0] cur_pos_q, cur_depth_q, prev_pos_q, prev_depth_q;
	logic signed [P-1:0] kept_lo_q, kept_hi_q;
	logic signed [GRAD_W-1:0] cur_grad_q, prev_grad_q;

	// Projection datapath.
	logic signed [P-1:0]      base_pos_q;
	logic signed [GRAD_W-1:0] base_grad_q;
	logic signed [SW-1:0]     dz_q;
	logic signed [SW-1:0]     sum_new_q, sum_old_q;
	logic signed [PRW-1:0]    prod_q;
	logic signed [PW-1:0]     proj_q;
	logic signed [DFW-1:0]    diff_new_q, diff_old_q;
	logic [DFW-1:0]           mag_new_q, mag_old_q;

	logic signed [SW-1:0]     div_dp_q, div_dz_q;
	logic                     acc_q, rep_q;
	logic                     out_valid_q;

	logic signed [PW-1:0]     span_lo_c, span_hi_c;
	logic                     inside_c;
	logic                     closer_c;
	logic                     start_ok_c;
	logic signed [P-1:0]      sel_pos_c;

	logic                     accept_c;
	logic                     do_start;
	logic                     do_commit;
	logic                     div_start;
	logic                     load_grad;
	logic                     load_out;
	logic                     div_done;
	logic signed [GRAD_W-1:0] div_quot;

	assign accept_c   = in_valid && !in_stall;
	assign start_ok_c = ({1'b0, layer_q} <= (5'(orient_q) + START_SLACK));
	// The stub's own orientation picks the coordinate of an offered cluster.
	assign sel_pos_c  = orient_bit_q ? x_q : y_q;
	assign span_lo_c  = {{(PW-P-FRAC_SHIFT){sl_q[P-1]}}, sl_q, {FRAC_SHIFT{1'b0}}};
	assign span_hi_c  = {{(PW-P-FRAC_SHIFT){sh_q[P-1]}}, sh_q, {FRAC_SHIFT{1'b0}}};
	assign inside_c   = (span_lo_c < proj_q) && (proj_q < span_hi_c);
	assign closer_c   = (mag_new_q < mag_old_q);

	always_comb begin
		priority if (!func_q || !has_q) begin
			kind_c = K_START;
		end else if ({1'b0, layer_q} == ({1'b0, cur_layer_q} + 5'(LAYER_STEP))) begin
			kind_c = K_ADVANCE;
		end else if (layer_q == cur_layer_q) begin
			kind_c = K_REPLACE;
		end else begin
			kind_c = K_REJECT;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:    if (in_valid) state_d = S_DECODE;
			S_DECODE: begin
				if (kind_c == K_START || kind_c == K_REJECT) begin
					state_d = S_EMIT;
				end else begin
					state_d = S_MUL;
				end
			end
			S_MUL:     state_d = S_PROJ;
			S_PROJ:    state_d = S_TEST;
			S_TEST: begin
				priority if (!inside_c) begin
					state_d = S_EMIT;
				end else if (kind_q == K_ADVANCE) begin
					state_d = S_COMMIT;
				end else begin
					state_d = S_ABS;
				end
			end
			S_ABS:     state_d = S_DIST;
			S_DIST:    state_d = closer_c ? S_COMMIT : S_EMIT;
			S_COMMIT:  state_d = S_DIVGO;
			S_DIVGO:   state_d = S_DIVWAIT;
			S_DIVWAIT: if (div_done) state_d = S_EMIT;
			S_EMIT:    if (!out_valid_q || !out_stall) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_stall  = (state_q != S_IDLE);
		do_start  = (state_q == S_DECODE) && (kind_c == K_START);
		do_commit = (state_q == S_COMMIT);
		div_start = (state_q == S_DIVGO);
		load_grad = (state_q == S_DIVWAIT) && div_done;
		load_out  = (state_q == S_EMIT) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_c) begin
			func_q   <= func;
			layer_q  <= layer;
			orient_q <= orient;
			x_q      <= x_pos;
			y_q      <= y_pos;
			z_q      <= z_pos;
			el_q     <= extent_low;
			eh_q     <= extent_high;
			sl_q     <= span_low;
			sh_q     <= span_high;
		end
		if (state_q == S_DECODE) begin
			kind_q    <= kind_c;
			sum_new_q <= SW'(el_q) + SW'(eh_q);
			sum_old_q <= SW'(kept_lo_q) + SW'(kept_hi_q);
			// An advance projects from the current layer, a replacement from
			// the previous one.
			if (kind_c == K_ADVANCE) begin
				base_pos_q  <= cur_pos_q;
				base_grad_q <= cur_grad_q;
				dz_q        <= SW'(z_q) - SW'(cur_depth_q);
			end else begin
				base_pos_q  <= prev_pos_q;
				base_grad_q <= prev_grad_q;
				dz_q        <= SW'(z_q) - SW'(prev_depth_q);
			end
		end
		if (state_q == S_MUL) begin
			prod_q <= base_grad_q * dz_q;
		end
		if (state_q == S_PROJ) begin
			proj_q <= {{(PW-P-FRAC_SHIFT){base_pos_q[P-1]}}, base_pos_q,
				{FRAC_SHIFT{1'b0}}} + PW'(prod_q);
		end
		if (state_q == S_TEST) begin
			diff_new_q <= DFW'(proj_q)
				- {{(DFW-SW-FRAC_SHIFT+1){sum_new_q[SW-1]}}, sum_new_q,
				{(FRAC_SHIFT-1){1'b0}}};
			diff_old_q <= DFW'(proj_q)
				- {{(DFW-SW-FRAC_SHIFT+1){sum_old_q[SW-1]}}, sum_old_q,
				{(FRAC_SHIFT-1){1'b0}}};
		end
		if (state_q == S_ABS) begin
			mag_new_q <= diff_new_q[DFW-1] ? (~diff_new_q + DFW'(1)) : diff_new_q;
			mag_old_q <= diff_old_q[DFW-1] ? (~diff_old_q + DFW'(1)) : diff_old_q;
		end
		if (do_commit) begin
			if (kind_q == K_ADVANCE) begin
				div_dp_q <= SW'(sel_pos_c) - SW'(cur_pos_q);
				div_dz_q <= SW'(z_q) - SW'(cur_depth_q);
			end else begin
				div_dp_q <= SW'($signed(sum_new_q[P:1])) - SW'(prev_pos_q);
				div_dz_q <= SW'(cur_depth_q) - SW'(prev_depth_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_q        <= 1'b0;
			cur_layer_q  <= '0;
			orient_bit_q <= 1'b0;
			cur_pos_q    <= '0;
			cur_depth_q  <= '0;
			cur_grad_q   <= '0;
			prev_pos_q   <= '0;
			prev_depth_q <= '0;
			prev_grad_q  <= '0;
			kept_lo_q    <= '0;
			kept_hi_q    <= '0;
			acc_q        <= 1'b0;
			rep_q        <= 1'b0;
		end else begin
			if (accept_c) begin
				acc_q <= 1'b0;
				rep_q <= 1'b0;
			end
			if (do_start) begin
				// A failed start check leaves the stub cleared.
				has_q        <= start_ok_c;
				cur_layer_q  <= start_ok_c ? layer_q : '0;
				orient_bit_q <= start_ok_c ? orient_q : 1'b0;
				cur_pos_q    <= start_ok_c ? (orient_q ? x_q : y_q) : '0;
				cur_depth_q  <= start_ok_c ? z_q : '0;
				kept_lo_q    <= start_ok_c ? el_q : '0;
				kept_hi_q    <= start_ok_c ? eh_q : '0;
				cur_grad_q   <= '0;
				prev_pos_q   <= '0;
				prev_depth_q <= '0;
				prev_grad_q  <= '0;
				acc_q        <= start_ok_c;
			end
			if (do_commit) begin
				acc_q     <= 1'b1;
				kept_lo_q <= el_q;
				kept_hi_q <= eh_q;
				if (kind_q == K_ADVANCE) begin
					prev_pos_q   <= cur_pos_q;
					prev_depth_q <= cur_depth_q;
					prev_grad_q  <= cur_grad_q;
					cur_layer_q  <= layer_q;
					cur_depth_q  <= z_q;
					cur_pos_q    <= sel_pos_c;
				end else begin
					// Floor of the extent centre: the half bit is dropped.
					cur_pos_q <= sum_new_q[P:1];
					rep_q     <= 1'b1;
				end
			end
			if (load_grad) begin
				cur_grad_q <= div_quot;
			end
		end
	end

	tsc_div #(
		.POS_WIDTH(POS_WIDTH)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.dp    (div_dp_q),
		.dz    (div_dz_q),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			accepted      <= acc_q;
			replaced      <= rep_q;
			stub_layer    <= cur_layer_q;
			stub_position <= cur_pos_q;
			stub_slope    <= cur_grad_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

### rtl/tsc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Track stub slope divider
// Restoring divider that forms (dp * 2^16) / dz truncated toward zero and
// saturated to the slope range, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsc_div
	import tsc_pkg::*;
#(
	parameter int POS_WIDTH = 20
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	input  wire logic signed [POS_WIDTH:0]   dp,
	input  wire logic signed [POS_WIDTH:0]   dz,
	output logic                             done,
	output logic signed [GRAD_W-1:0]         quot
);

	localparam int NW = POS_WIDTH + 1;
	localparam int DW = NW + GRAD_W;

	div_state_t state_q, state_d;

	logic              neg_q;
	logic              nz_q;
	logic              ovf_q;
	logic [DW-1:0]     rem_q;
	logic [DW-1:0]     dsh_q;
	logic [GRAD_W-1:0] quo_q;
	logic [4:0]        cnt_q;

	logic [NW-1:0]     dp_mag_c;
	logic [NW-1:0]     dz_mag_c;
	logic              ge_c;

	assign dp_mag_c = dp[NW-1] ? (~dp + NW'(1)) : dp;
	assign dz_mag_c = dz[NW-1] ? (~dz + NW'(1)) : dz;
	assign ge_c     = (rem_q >= dsh_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			D_IDLE:  if (start) state_d = D_CHECK;
			D_CHECK: state_d = D_ITER;
			D_ITER:  if (cnt_q == 5'd0) state_d = D_DONE;
			D_DONE:  state_d = D_IDLE;
			default: state_d = D_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			D_IDLE: begin
				if (start) begin
					neg_q <= dp[NW-1] ^ dz[NW-1];
					nz_q  <= (dp != '0);
					rem_q <= DW'({dp_mag_c, {FRAC_SHIFT{1'b0}}});
					dsh_q <= {dz_mag_c, {GRAD_W{1'b0}}};
				end
			end
			D_CHECK: begin
				// A quotient of 2^21 or more saturates whatever its sign.
				ovf_q <= ge_c;
				dsh_q <= dsh_q >> 1;
				quo_q <= '0;
				cnt_q <= 5'(GRAD_W - 1);
			end
			D_ITER: begin
				if (ge_c) begin
					rem_q <= rem_q - dsh_q;
				end
				quo_q <= {quo_q[GRAD_W-2:0], ge_c};
				dsh_q <= dsh_q >> 1;
				cnt_q <= cnt_q - 5'd1;
			end
			D_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		done = (state_q == D_DONE);
		priority if (!nz_q) begin
			quot = '0;
		end else if (ovf_q) begin
			quot = neg_q ? GRAD_MIN : GRAD_MAX;
		end else if (!neg_q) begin
			quot = quo_q[GRAD_W-1] ? GRAD_MAX : $signed(quo_q);
		end else begin
			quot = (quo_q > {1'b1, {(GRAD_W-1){1'b0}}}) ? GRAD_MIN : $signed(-quo_q);
		end
	end

endmodule
`default_nettype wire

### rtl/tsc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Track stub follower port checker
// Watches the ports of the follower core over time and is bound to it.
// ----------------------------------------------------------------------------
module tsc_checker
	import tsc_pkg::*;
#(
	parameter int POS_WIDTH = 20
) (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              in_valid,
	input wire                              in_stall,
	input wire                              out_valid,
	input wire                              out_stall,
	input wire                              accepted,
	input wire                              replaced,
	input wire  [3:0]                       stub_layer,
	input wire logic signed [POS_WIDTH-1:0] stub_position,
	input wire logic signed [GRAD_W-1:0]    stub_slope
);

	// A replacement is always reported as an accepted cluster.
	a_rep_implies_acc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!replaced || accepted))
		else $error("replaced without accepted");

	// One item at a time: the block stalls right after taking an item.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after an accepted item");

	// No result can appear in the cycle right after an item is taken.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !out_valid) |=> !out_valid)
		else $error("result appeared too early");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(accepted)
		&& $stable(replaced) && $stable(stub_layer) && $stable(stub_position)
		&& $stable(stub_slope)))
		else $error("stalled result changed");

endmodule

bind track_stub_cluster_follower_core tsc_checker #(
	.POS_WIDTH(POS_WIDTH)
) u_tsc_checker (.*);
`default_nettype wire
